// File: rtl/bpfs_pkg.sv
// Shared types, constants and helpers for the block pool free stack allocator.
`timescale 1ns / 1ps

package bpfs_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic sweep_start;
        logic sweep_step;
        logic capture;
        logic execute;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } t_dp_stat;

    // Zero is taken as one block, anything above the pool size as the pool size.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(MAX_BLOCKS)) begin
            r = CNT_W'(MAX_BLOCKS);
        end
        return r;
    endfunction

endpackage

// File: rtl/bpfs_ctrl.sv
// Sequencing FSM: clearing pass, request capture and execute.
`timescale 1ns / 1ps

module bpfs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cfg_we,
    input  bpfs_pkg::t_dp_stat i_stat,
    output bpfs_pkg::t_dp_cmd  o_cmd
);

    bpfs_pkg::t_state r_state;
    bpfs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpfs_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        o_cmd.sweep_start = i_cfg_we;
        unique case (r_state)
            bpfs_pkg::S_INIT: begin
                o_cmd.sweep_step = !i_cfg_we;
                if (!i_cfg_we && i_stat.sweep_last) begin
                    n_state = bpfs_pkg::S_IDLE;
                end
            end
            bpfs_pkg::S_IDLE: begin
                o_in_ready = !i_cfg_we;
                if (i_cfg_we) begin
                    n_state = bpfs_pkg::S_INIT;
                end else if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bpfs_pkg::S_EXEC;
                end
            end
            bpfs_pkg::S_EXEC: begin
                if (i_cfg_we) begin
                    n_state = bpfs_pkg::S_INIT;
                end else if (i_stat.out_free) begin
                    o_cmd.execute = 1'b1;
                    n_state       = bpfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpfs_pkg::S_INIT;
            end
        endcase
    end

endmodule

// File: rtl/bpfs_datapath.sv
// Free stack and free flag memories, top pointer, pool size and result register.
`timescale 1ns / 1ps

module bpfs_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpfs_pkg::t_dp_cmd          i_cmd,
    output bpfs_pkg::t_dp_stat         o_stat,
    input  logic [bpfs_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_command,
    input  logic [bpfs_pkg::IDX_W-1:0] i_block_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [bpfs_pkg::IDX_W-1:0] o_granted_index,
    output logic [bpfs_pkg::CNT_W-1:0] o_blocks_in_use
);

    localparam int IW = bpfs_pkg::IDX_W;
    localparam int CW = bpfs_pkg::CNT_W;

    logic [IW-1:0] r_stack [bpfs_pkg::MAX_BLOCKS];
    logic          r_flags [bpfs_pkg::MAX_BLOCKS];

    logic [CW-1:0] r_block_count;
    logic [CW-1:0] r_top;
    logic [CW-1:0] n_top;
    logic [IW-1:0] r_sweep;
    logic          r_cmd;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_stk_rd;
    logic          r_flg_rd;

    logic             r_out_valid;
    logic             n_out_valid;
    bpfs_pkg::t_status r_out_status;
    bpfs_pkg::t_status n_out_status;
    logic [IW-1:0]    r_out_gidx;
    logic [IW-1:0]    n_out_gidx;
    logic [CW-1:0]    r_out_used;

    logic          stk_we;
    logic [IW-1:0] stk_wa;
    logic [IW-1:0] stk_wd;
    logic          flg_we;
    logic [IW-1:0] flg_wa;
    logic          flg_wd;
    logic [CW-1:0] top_dec;

    assign top_dec = r_top - CW'(1);

    // Decision for the captured transaction, plus memory write selection.
    always_comb begin
        n_top        = r_top;
        n_out_status = bpfs_pkg::ST_OK;
        n_out_gidx   = '0;
        stk_we       = 1'b0;
        stk_wa       = r_sweep;
        stk_wd       = r_sweep;
        flg_we       = 1'b0;
        flg_wa       = r_sweep;
        flg_wd       = 1'b1;
        if (i_cmd.sweep_step) begin
            stk_we = 1'b1;
            flg_we = 1'b1;
        end else if (i_cmd.execute) begin
            if (r_cmd == bpfs_pkg::CMD_ALLOC) begin
                if (r_top >= r_block_count) begin
                    n_out_status = bpfs_pkg::ST_EMPTY;
                end else begin
                    n_top      = r_top + CW'(1);
                    n_out_gidx = r_stk_rd;
                    flg_we     = 1'b1;
                    flg_wa     = r_stk_rd;
                    flg_wd     = 1'b0;
                end
            end else begin
                if ({1'b0, r_idx} >= r_block_count) begin
                    n_out_status = bpfs_pkg::ST_RANGE;
                end else if (r_flg_rd) begin
                    n_out_status = bpfs_pkg::ST_FREED;
                end else if (r_top != '0) begin
                    n_top  = top_dec;
                    flg_we = 1'b1;
                    flg_wa = r_idx;
                    flg_wd = 1'b1;
                    stk_we = 1'b1;
                    stk_wa = top_dec[IW-1:0];
                    stk_wd = r_idx;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= stk_wd;
        end
        if (i_cmd.capture) begin
            r_stk_rd <= r_stack[r_top[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (flg_we) begin
            r_flags[flg_wa] <= flg_wd;
        end
        if (i_cmd.capture) begin
            r_flg_rd <= r_flags[i_block_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= CW'(bpfs_pkg::MAX_BLOCKS);
            r_top         <= '0;
            r_sweep       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cmd.sweep_start) begin
                r_block_count <= bpfs_pkg::clamp_count(i_cfg_data);
                r_top         <= '0;
                r_sweep       <= '0;
            end else begin
                r_top <= n_top;
                if (i_cmd.sweep_step) begin
                    r_sweep <= r_sweep + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_idx <= i_block_index;
        end
        if (i_cmd.execute) begin
            r_out_status <= n_out_status;
            r_out_gidx   <= n_out_gidx;
            r_out_used   <= n_top;
        end
    end

    assign o_stat.sweep_last = (r_sweep == IW'(bpfs_pkg::MAX_BLOCKS - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = r_out_gidx;
    assign o_blocks_in_use = r_out_used;

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_block_count)
        else $error("stack top beyond pool size");

    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> r_out_valid)
        else $error("executed transaction left no result");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != bpfs_pkg::ST_OK) |-> (r_out_gidx == '0))
        else $error("granted index nonzero on error");

    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

// File: rtl/block_pool_free_stack_allocator_unit.sv
// Top level of the block pool free stack allocator.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   request  | i_in_valid / o_in_ready    | i_command, i_block_index
//   result   | o_out_valid / i_out_ready  | o_status, o_granted_index, o_blocks_in_use
//   config   | i_cfg_we                   | i_cfg_data (block_count)
//
// Each transaction is a capture with the stack and flag memory reads,
// then an execute on the registered read data with the memory writes.
// A result waiting in the output register does not block the next capture;
// execute waits only while that register is still full.
// After reset and after every block_count write a clearing pass reloads
// both memories; no request is taken during it.
`timescale 1ns / 1ps

module block_pool_free_stack_allocator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [bpfs_pkg::IDX_W-1:0] i_block_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [bpfs_pkg::IDX_W-1:0] o_granted_index,
    output logic [bpfs_pkg::CNT_W-1:0] o_blocks_in_use,
    input  logic                       i_cfg_we,
    input  logic [bpfs_pkg::CNT_W-1:0] i_cfg_data
);

    bpfs_pkg::t_dp_cmd  dp_cmd;
    bpfs_pkg::t_dp_stat dp_stat;

    bpfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cfg_we   (i_cfg_we),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bpfs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_block_index   (i_block_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_blocks_in_use (o_blocks_in_use)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the block pool free stack allocator.
`timescale 1ns / 1ps

module tb;

    typedef enum logic [1:0] {
        ACT_REQ,
        ACT_CFG,
        ACT_WAIT
    } t_pool_action;

    typedef struct {
        t_pool_action               action;
        logic                       cmd;
        logic [bpfs_pkg::IDX_W-1:0] idx;
        logic [bpfs_pkg::CNT_W-1:0] cfg_val;
        int                         gap;
        bit                         calm;
    } t_pool_step;

    typedef struct packed {
        bpfs_pkg::t_status          status;
        logic [bpfs_pkg::IDX_W-1:0] granted;
        logic [bpfs_pkg::CNT_W-1:0] in_use;
    } t_alloc_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_command = bpfs_pkg::CMD_ALLOC;
    logic [bpfs_pkg::IDX_W-1:0] i_block_index = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [1:0]                 o_status;
    logic [bpfs_pkg::IDX_W-1:0] o_granted_index;
    logic [bpfs_pkg::CNT_W-1:0] o_blocks_in_use;
    logic                       i_cfg_we = 1'b0;
    logic [bpfs_pkg::CNT_W-1:0] i_cfg_data = '0;

    block_pool_free_stack_allocator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_block_index  (i_block_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_granted_index(o_granted_index),
        .o_blocks_in_use(o_blocks_in_use),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predicted allocator state
    logic [bpfs_pkg::IDX_W-1:0]      pool_stack [bpfs_pkg::MAX_BLOCKS];
    logic [bpfs_pkg::MAX_BLOCKS-1:0] pool_free;
    int                              pool_top;
    int                              pool_used;
    int                              pool_size;

    t_pool_step    pending_q [$];
    t_alloc_result grant_expect_q [$];
    int            n_sent = 0;
    int            n_recv = 0;
    int            fail_count = 0;
    int            gap_cnt = 0;
    int            stall_left = 0;
    bit            rx_calm = 1'b0;
    bit            rx_noisy = 1'b1;
    bit            gen_noisy = 1'b1;
    bit            drv_take;
    bit            drv_load;
    bit            drv_write;
    t_alloc_result mon_exp;

    function automatic void pool_reload(input logic [bpfs_pkg::CNT_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) n = 1;
        if (n > bpfs_pkg::MAX_BLOCKS) n = bpfs_pkg::MAX_BLOCKS;
        pool_size = n;
        for (int i = 0; i < bpfs_pkg::MAX_BLOCKS; i++) begin
            pool_stack[i] = bpfs_pkg::IDX_W'(i);
        end
        pool_free = '1;
        pool_top  = 0;
        pool_used = 0;
    endfunction

    function automatic t_alloc_result pool_apply(input logic cmd,
                                                 input logic [bpfs_pkg::IDX_W-1:0] idx);
        t_alloc_result r;
        r.status  = bpfs_pkg::ST_OK;
        r.granted = '0;
        if (cmd == bpfs_pkg::CMD_ALLOC) begin
            if (pool_top >= pool_size) begin
                r.status = bpfs_pkg::ST_EMPTY;
            end else begin
                r.granted = pool_stack[pool_top];
                pool_free[r.granted] = 1'b0;
                pool_top++;
                pool_used++;
            end
        end else begin
            if (int'(idx) >= pool_size) begin
                r.status = bpfs_pkg::ST_RANGE;
            end else if (pool_free[idx]) begin
                r.status = bpfs_pkg::ST_FREED;
            end else if (pool_top > 0) begin
                pool_free[idx] = 1'b1;
                pool_top--;
                pool_stack[pool_top] = idx;
                if (pool_used > 0) pool_used--;
            end
        end
        r.in_use = bpfs_pkg::CNT_W'(pool_used);
        return r;
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_we   <= 1'b0;
            gap_cnt    <= 0;
            pool_reload(bpfs_pkg::CNT_W'(bpfs_pkg::MAX_BLOCKS));
        end else begin
            drv_take  = i_in_valid && o_in_ready;
            drv_load  = 1'b0;
            drv_write = 1'b0;
            if (drv_take) begin
                grant_expect_q.push_back(pool_apply(i_command, i_block_index));
                n_sent <= n_sent + 1;
            end
            if ((!i_in_valid || drv_take) && pending_q.size() > 0) begin
                case (pending_q[0].action)
                    ACT_REQ: begin
                        if (gap_cnt < pending_q[0].gap) begin
                            gap_cnt <= gap_cnt + 1;
                        end else begin
                            drv_load = 1'b1;
                            gap_cnt <= 0;
                        end
                    end
                    ACT_CFG: begin
                        // only once the pipeline has fully drained
                        if (!i_in_valid && n_sent == n_recv) begin
                            if (gap_cnt < 4) begin
                                gap_cnt <= gap_cnt + 1;
                            end else begin
                                drv_write = 1'b1;
                                gap_cnt <= 0;
                            end
                        end
                    end
                    default: begin
                        if (!i_in_valid && n_sent == n_recv) begin
                            void'(pending_q.pop_front());
                        end
                    end
                endcase
            end
            if (drv_load) begin
                i_command     <= pending_q[0].cmd;
                i_block_index <= pending_q[0].idx;
                rx_calm       <= pending_q[0].calm;
                void'(pending_q.pop_front());
            end
            if (drv_write) begin
                i_cfg_data <= pending_q[0].cfg_val;
                pool_reload(pending_q[0].cfg_val);
                void'(pending_q.pop_front());
            end
            i_in_valid <= drv_load ? 1'b1 : (drv_take ? 1'b0 : i_in_valid);
            i_cfg_we   <= drv_write;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_recv <= n_recv + 1;
                if (grant_expect_q.size() == 0) begin
                    $error("unexpected result transaction: status %0d index %0d in_use %0d",
                           o_status, o_granted_index, o_blocks_in_use);
                    fail_count++;
                end else begin
                    mon_exp = grant_expect_q.pop_front();
                    if (o_status !== mon_exp.status) begin
                        $error("status: expected %0d, actual %0d", mon_exp.status, o_status);
                        fail_count++;
                    end
                    if (o_granted_index !== mon_exp.granted) begin
                        $error("granted_index: expected %0d, actual %0d",
                               mon_exp.granted, o_granted_index);
                        fail_count++;
                    end
                    if (o_blocks_in_use !== mon_exp.in_use) begin
                        $error("blocks_in_use: expected %0d, actual %0d",
                               mon_exp.in_use, o_blocks_in_use);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) rx_noisy <= !rx_noisy;
            if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (!rx_calm && rx_noisy && $urandom_range(0, 3) == 0) begin
                stall_left  <= $urandom_range(0, 10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap(input bit calm);
        if (calm) return 0;
        if ($urandom_range(0, 31) == 0) gen_noisy = !gen_noisy;
        if (gen_noisy && $urandom_range(0, 3) == 0) return $urandom_range(1, 11);
        return 0;
    endfunction

    task automatic add_req(input logic cmd, input int idx, input bit calm = 1'b0);
        t_pool_step s;
        s.action  = ACT_REQ;
        s.cmd     = cmd;
        s.idx     = bpfs_pkg::IDX_W'(idx);
        s.cfg_val = '0;
        s.gap     = pick_gap(calm);
        s.calm    = calm;
        pending_q.push_back(s);
    endtask

    task automatic add_ctl(input t_pool_action act, input int v = 0);
        t_pool_step s;
        s.action  = act;
        s.cmd     = bpfs_pkg::CMD_ALLOC;
        s.idx     = '0;
        s.cfg_val = bpfs_pkg::CNT_W'(v);
        s.gap     = 0;
        s.calm    = 1'b0;
        pending_q.push_back(s);
    endtask

    // Allocates and releases in equal measure; most releases name blocks in the pool.
    task automatic add_mixed(input int blocks, input int n_items, input bit calm = 1'b0);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                add_req(bpfs_pkg::CMD_ALLOC, $urandom_range(0, bpfs_pkg::MAX_BLOCKS - 1), calm);
            end else if ($urandom_range(0, 4) != 0) begin
                add_req(bpfs_pkg::CMD_RELEASE, $urandom_range(0, blocks - 1), calm);
            end else begin
                add_req(bpfs_pkg::CMD_RELEASE, $urandom_range(0, bpfs_pkg::MAX_BLOCKS - 1),
                        calm);
            end
        end
    endtask

    initial begin
        int blocks;

        // default pool after reset
        add_req(bpfs_pkg::CMD_ALLOC, 0);
        add_req(bpfs_pkg::CMD_ALLOC, 1023);
        add_req(bpfs_pkg::CMD_RELEASE, 1023);
        add_req(bpfs_pkg::CMD_RELEASE, 1);
        add_req(bpfs_pkg::CMD_RELEASE, 1);
        add_req(bpfs_pkg::CMD_ALLOC, 0);
        add_req(bpfs_pkg::CMD_RELEASE, 0);
        add_req(bpfs_pkg::CMD_ALLOC, 0);
        add_req(bpfs_pkg::CMD_RELEASE, 1);
        add_req(bpfs_pkg::CMD_RELEASE, 0);

        // zero is taken as a single block
        add_ctl(ACT_CFG, 0);
        add_req(bpfs_pkg::CMD_ALLOC, 0);
        add_req(bpfs_pkg::CMD_ALLOC, 0);
        add_req(bpfs_pkg::CMD_RELEASE, 1);
        add_req(bpfs_pkg::CMD_RELEASE, 1023);
        add_req(bpfs_pkg::CMD_RELEASE, 0);
        add_req(bpfs_pkg::CMD_RELEASE, 0);

        // oversize count clamps to the full pool; run it dry
        add_ctl(ACT_CFG, 2047);
        add_req(bpfs_pkg::CMD_ALLOC, 0);
        add_req(bpfs_pkg::CMD_RELEASE, 1023);
        for (int i = 0; i < 1030; i++) begin
            add_req(bpfs_pkg::CMD_ALLOC, $urandom_range(0, bpfs_pkg::MAX_BLOCKS - 1));
            if ($urandom_range(0, 19) == 0) begin
                add_req(bpfs_pkg::CMD_RELEASE, $urandom_range(0, bpfs_pkg::MAX_BLOCKS - 1));
                add_req(bpfs_pkg::CMD_ALLOC, 0);
            end
        end

        add_ctl(ACT_CFG, 2);
        add_mixed(2, 150);

        blocks = $urandom_range(3, 24);
        add_ctl(ACT_CFG, blocks);
        add_mixed(blocks, 75);
        add_ctl(ACT_WAIT);
        add_mixed(blocks, 75);

        blocks = $urandom_range(25, 200);
        add_ctl(ACT_CFG, blocks);
        add_mixed(blocks, 150);

        add_ctl(ACT_CFG, 1025);
        add_mixed(bpfs_pkg::MAX_BLOCKS, 40);

        // closing stretch at full rate
        add_ctl(ACT_CFG, 1);
        add_mixed(1, 80, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || i_in_valid) @(negedge i_clk);
        for (int i = 0; i < 5000 && n_recv != n_sent; i++) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (grant_expect_q.size() != 0) begin
            $error("%0d result transactions never arrived", grant_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
